@@ src/usbep0_pkg.sv @@
// Shared types and constants for the USB endpoint-0 control transfer handler.
// Holds the event and result payload structs, request and handshake codes.
`timescale 1ns / 1ps

package usbep0_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_LEN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CONFIG_LEN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LANGUAGE_LEN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VENDOR_LEN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PRODUCT_LEN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_REPORT_LEN   = 3'd5;

  localparam logic [1:0] CMD_SETUP     = 2'd0;
  localparam logic [1:0] CMD_IN_DONE   = 2'd1;
  localparam logic [1:0] CMD_OUT_DONE  = 2'd2;
  localparam logic [1:0] CMD_BUS_RESET = 2'd3;

  localparam logic [7:0] RQ_ZERO              = 8'h00;
  localparam logic [7:0] RQ_SET_ADDRESS       = 8'h05;
  localparam logic [7:0] RQ_GET_DESCRIPTOR    = 8'h06;
  localparam logic [7:0] RQ_GET_CONFIGURATION = 8'h08;
  localparam logic [7:0] RQ_SET_CONFIGURATION = 8'h09;
  localparam logic [7:0] RQ_SET_IDLE          = 8'h0A;
  localparam logic [7:0] RQ_STALLED           = 8'hFF;

  localparam logic [7:0] DT_DEVICE     = 8'h01;
  localparam logic [7:0] DT_CONFIG     = 8'h02;
  localparam logic [7:0] DT_STRING     = 8'h03;
  localparam logic [7:0] DT_HID_REPORT = 8'h22;
  localparam logic [7:0] MAX_STRING    = 8'd2;
  localparam logic [7:0] VENDOR_MODE   = 8'h40;
  localparam logic [6:0] SETUP_BYTES   = 7'd8;

  localparam logic [1:0] HS_NAK   = 2'd0;
  localparam logic [1:0] HS_ACK   = 2'd1;
  localparam logic [1:0] HS_STALL = 2'd2;
  localparam logic       OHS_ACK   = 1'b0;
  localparam logic       OHS_STALL = 1'b1;

  localparam logic [2:0] DESC_NONE     = 3'd0;
  localparam logic [2:0] DESC_DEVICE   = 3'd1;
  localparam logic [2:0] DESC_CONFIG   = 3'd2;
  localparam logic [2:0] DESC_LANGUAGE = 3'd3;
  localparam logic [2:0] DESC_VENDOR   = 3'd4;
  localparam logic [2:0] DESC_PRODUCT  = 3'd5;
  localparam logic [2:0] DESC_REPORT   = 3'd6;

  typedef struct packed {
    logic [1:0]  command;
    logic [6:0]  rx_length;
    logic [7:0]  request_type;
    logic [7:0]  request_code;
    logic [7:0]  value_low;
    logic [7:0]  value_high;
    logic [7:0]  index_low;
    logic [15:0] request_length;
  } ep0_event_t;

  typedef struct packed {
    logic [1:0] in_response;
    logic       out_response;
    logic [3:0] tx_length;
    logic       in_data_toggle;
    logic       out_data_toggle;
    logic [2:0] descriptor_select;
    logic [9:0] descriptor_offset;
    logic [7:0] reply_byte;
    logic [6:0] device_address;
    logic       configured;
    logic       command_pending;
  } ep0_result_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] sel;
    logic [9:0] length;
  } desc_info_t;

endpackage

@@ src/usbep0_desc.sv @@
// Descriptor length registers and GET_DESCRIPTOR target decode.
// Depends on usbep0_pkg for codes and the descriptor info struct.
`timescale 1ns / 1ps

module usbep0_desc (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [usbep0_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [usbep0_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic [7:0]                           value_low,
  input  logic [7:0]                           value_high,
  input  logic [7:0]                           index_low,
  output usbep0_pkg::desc_info_t               info
);
  import usbep0_pkg::*;

  logic [7:0] device_len_r;
  logic [9:0] config_len_r;
  logic [7:0] language_len_r;
  logic [7:0] vendor_len_r;
  logic [7:0] product_len_r;
  logic [9:0] report_len_r;
  logic [2:0] sel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      device_len_r   <= 8'd18;
      config_len_r   <= 10'd34;
      language_len_r <= 8'd4;
      vendor_len_r   <= 8'd16;
      product_len_r  <= 8'd16;
      report_len_r   <= 10'd64;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEVICE_LEN:   device_len_r   <= cfg_data[7:0];
        CFG_CONFIG_LEN:   config_len_r   <= cfg_data;
        CFG_LANGUAGE_LEN: language_len_r <= cfg_data[7:0];
        CFG_VENDOR_LEN:   vendor_len_r   <= cfg_data[7:0];
        CFG_PRODUCT_LEN:  product_len_r  <= cfg_data[7:0];
        CFG_REPORT_LEN:   report_len_r   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    sel = DESC_NONE;
    if (value_high == DT_DEVICE) begin
      sel = DESC_DEVICE;
    end else if (value_high == DT_CONFIG) begin
      sel = DESC_CONFIG;
    end else if (value_high == DT_STRING && value_low <= MAX_STRING) begin
      sel = DESC_LANGUAGE + value_low[2:0];
    end else if (value_high == DT_HID_REPORT && index_low == 8'd0) begin
      sel = DESC_REPORT;
    end
  end

  always_comb begin
    info.sel = sel;
    info.hit = (sel != DESC_NONE);
    case (sel)
      DESC_DEVICE:   info.length = {2'b00, device_len_r};
      DESC_CONFIG:   info.length = config_len_r;
      DESC_LANGUAGE: info.length = {2'b00, language_len_r};
      DESC_VENDOR:   info.length = {2'b00, vendor_len_r};
      DESC_PRODUCT:  info.length = {2'b00, product_len_r};
      DESC_REPORT:   info.length = report_len_r;
      default:       info.length = 10'd0;
    endcase
  end

endmodule

@@ src/usbep0_ctrl.sv @@
// Control transfer state and per-event update logic for endpoint 0.
// Depends on usbep0_pkg; takes the descriptor decode from usbep0_desc.
`timescale 1ns / 1ps

module usbep0_ctrl #(
  parameter int CHUNK_BYTES = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     fire,
  input  usbep0_pkg::ep0_event_t   ev,
  input  usbep0_pkg::desc_info_t   desc,
  output usbep0_pkg::ep0_result_t  res
);
  import usbep0_pkg::*;

  localparam int CW = $clog2(CHUNK_BYTES + 1);
  localparam logic [15:0]   CHUNK_LEN = 16'(CHUNK_BYTES);
  localparam logic [CW-1:0] CHUNK_N   = CW'(CHUNK_BYTES);

  logic [15:0] rem_r,        rem_nxt;
  logic [7:0]  act_r,        act_nxt;
  logic [2:0]  cur_desc_r,   cur_desc_nxt;
  logic [9:0]  chunk_off_r,  chunk_off_nxt;
  logic [7:0]  cfg_val_r,    cfg_val_nxt;
  logic [6:0]  addr_r,       addr_nxt;
  logic        enum_r,       enum_nxt;
  logic        in_tog_r,     in_tog_nxt;
  logic        out_tog_r,    out_tog_nxt;
  logic        cmd_flag_r,   cmd_flag_nxt;
  logic [1:0]  in_hs_r,      in_hs_nxt;
  logic        out_hs_r,     out_hs_nxt;
  logic [3:0]  tx_len_r,     tx_len_nxt;

  logic          is_setup;
  logic [15:0]   capped_len;
  logic [15:0]   base_len;
  logic [9:0]    base_off;
  logic [CW-1:0] chunk_n;
  logic [15:0]   rem_after;
  logic [9:0]    off_after;
  logic          fail;
  logic [3:0]    setup_tx;
  logic [2:0]    sel_out;
  logic [9:0]    off_out;
  logic [7:0]    reply;

  // One chunk unit serves both the setup stage and later IN completions.
  assign is_setup   = (ev.command == CMD_SETUP);
  assign capped_len = (ev.request_length > {6'd0, desc.length}) ?
                      {6'd0, desc.length} : ev.request_length;
  assign base_len   = is_setup ? capped_len : rem_r;
  assign base_off   = is_setup ? 10'd0 : chunk_off_r;
  assign chunk_n    = (base_len >= CHUNK_LEN) ? CHUNK_N : base_len[CW-1:0];
  assign rem_after  = base_len - 16'(chunk_n);
  assign off_after  = base_off + 10'(chunk_n);

  always_comb begin
    rem_nxt       = rem_r;
    act_nxt       = act_r;
    cur_desc_nxt  = cur_desc_r;
    chunk_off_nxt = chunk_off_r;
    cfg_val_nxt   = cfg_val_r;
    addr_nxt      = addr_r;
    enum_nxt      = enum_r;
    in_tog_nxt    = in_tog_r;
    out_tog_nxt   = out_tog_r;
    cmd_flag_nxt  = cmd_flag_r;
    in_hs_nxt     = in_hs_r;
    out_hs_nxt    = out_hs_r;
    tx_len_nxt    = tx_len_r;
    fail          = 1'b0;
    setup_tx      = 4'd0;
    sel_out       = DESC_NONE;
    off_out       = 10'd0;
    reply         = 8'd0;

    case (ev.command)
      CMD_SETUP: begin
        if (ev.rx_length != SETUP_BYTES) begin
          fail = 1'b1;
        end else begin
          rem_nxt = ev.request_length;
          act_nxt = ev.request_code;
          case (ev.request_code)
            RQ_GET_DESCRIPTOR: begin
              if (!desc.hit) begin
                fail = 1'b1;
              end else begin
                cur_desc_nxt  = desc.sel;
                rem_nxt       = rem_after;
                chunk_off_nxt = off_after;
                setup_tx      = chunk_n[3:0];
                sel_out       = desc.sel;
                off_out       = base_off;
              end
            end
            RQ_SET_ADDRESS: begin
              rem_nxt = {8'd0, ev.value_low};
            end
            RQ_GET_CONFIGURATION: begin
              reply = cfg_val_r;
              if (ev.request_length != 16'd0) begin
                setup_tx = 4'd1;
              end
            end
            RQ_SET_CONFIGURATION: begin
              cfg_val_nxt = ev.value_low;
              enum_nxt    = 1'b1;
            end
            RQ_SET_IDLE: begin
            end
            RQ_ZERO: begin
              cfg_val_nxt = ev.request_type;
            end
            default: begin
              fail = 1'b1;
            end
          endcase
        end
        if (fail) begin
          act_nxt     = RQ_STALLED;
          in_hs_nxt   = HS_STALL;
          out_hs_nxt  = OHS_STALL;
          in_tog_nxt  = 1'b1;
          out_tog_nxt = 1'b1;
          reply       = 8'd0;
        end else begin
          tx_len_nxt  = setup_tx;
          in_hs_nxt   = HS_ACK;
          out_hs_nxt  = OHS_ACK;
          in_tog_nxt  = 1'b1;
          out_tog_nxt = 1'b1;
        end
      end
      CMD_IN_DONE: begin
        if (act_r == RQ_GET_DESCRIPTOR) begin
          tx_len_nxt    = chunk_n[3:0];
          rem_nxt       = rem_after;
          chunk_off_nxt = off_after;
          sel_out       = cur_desc_r;
          off_out       = base_off;
          in_tog_nxt    = ~in_tog_r;
        end else begin
          if (act_r == RQ_SET_ADDRESS) begin
            addr_nxt = rem_r[6:0];
          end else begin
            tx_len_nxt = 4'd0;
          end
          in_hs_nxt   = HS_NAK;
          out_hs_nxt  = OHS_ACK;
          in_tog_nxt  = 1'b0;
          out_tog_nxt = 1'b0;
        end
      end
      CMD_OUT_DONE: begin
        if (cfg_val_r == VENDOR_MODE) begin
          cmd_flag_nxt = 1'b1;
        end
        tx_len_nxt  = 4'd0;
        out_tog_nxt = ~out_tog_r;
      end
      CMD_BUS_RESET: begin
        addr_nxt = 7'd0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r       <= 16'd0;
      act_r       <= 8'd0;
      cur_desc_r  <= DESC_NONE;
      chunk_off_r <= 10'd0;
      cfg_val_r   <= 8'd0;
      addr_r      <= 7'd0;
      enum_r      <= 1'b0;
      in_tog_r    <= 1'b0;
      out_tog_r   <= 1'b0;
      cmd_flag_r  <= 1'b0;
      in_hs_r     <= HS_NAK;
      out_hs_r    <= OHS_ACK;
      tx_len_r    <= 4'd0;
    end else if (fire) begin
      rem_r       <= rem_nxt;
      act_r       <= act_nxt;
      cur_desc_r  <= cur_desc_nxt;
      chunk_off_r <= chunk_off_nxt;
      cfg_val_r   <= cfg_val_nxt;
      addr_r      <= addr_nxt;
      enum_r      <= enum_nxt;
      in_tog_r    <= in_tog_nxt;
      out_tog_r   <= out_tog_nxt;
      cmd_flag_r  <= cmd_flag_nxt;
      in_hs_r     <= in_hs_nxt;
      out_hs_r    <= out_hs_nxt;
      tx_len_r    <= tx_len_nxt;
    end
  end

  always_comb begin
    res.in_response       = in_hs_nxt;
    res.out_response      = out_hs_nxt;
    res.tx_length         = tx_len_nxt;
    res.in_data_toggle    = in_tog_nxt;
    res.out_data_toggle   = out_tog_nxt;
    res.descriptor_select = sel_out;
    res.descriptor_offset = off_out;
    res.reply_byte        = reply;
    res.device_address    = addr_nxt;
    res.configured        = enum_nxt;
    res.command_pending   = cmd_flag_nxt;
  end

endmodule

@@ src/usb_control_endpoint_handler.sv @@
// Top level of the USB endpoint-0 control transfer handler.
// Instantiates usbep0_desc and usbep0_ctrl; uses types from usbep0_pkg.
`timescale 1ns / 1ps

// Each request is one endpoint-0 event (setup, IN done, OUT done or bus reset)
// and yields exactly one result. The block takes one request per clock while
// the output is not stalled; a request is held in the input register until it
// advances, is decoded in a single pass, and its result is then presented from
// the result register. The user must write descriptor lengths on the
// configuration port only while no request is in flight; the block itself
// does not enforce this. Bus reset clears only the device address.

module usb_control_endpoint_handler #(
  parameter int CHUNK_BYTES = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  usbep0_pkg::ep0_event_t            in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output usbep0_pkg::ep0_result_t           out_data,
  input  logic                              cfg_we,
  input  logic [usbep0_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [usbep0_pkg::CFG_DATA_W-1:0] cfg_data
);
  import usbep0_pkg::*;

  logic        ev_valid_r;
  ep0_event_t  ev_r;
  logic        out_valid_r;
  ep0_result_t out_data_r;
  logic        advance;
  desc_info_t  desc;
  ep0_result_t res;

  assign advance  = ev_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = ev_valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      ev_valid_r <= 1'b1;
    end else if (advance) begin
      ev_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      ev_r <= in_data;
    end
  end

  usbep0_desc u_desc (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .value_low  (ev_r.value_low),
    .value_high (ev_r.value_high),
    .index_low  (ev_r.index_low),
    .info       (desc)
  );

  usbep0_ctrl #(
    .CHUNK_BYTES (CHUNK_BYTES)
  ) u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (advance),
    .ev    (ev_r),
    .desc  (desc),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
